/* hw/rtl/e2q_pkg.sv */
package e2q_pkg;

    // cordic depth; the arctangent table caps it at its length
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int NUM_ITER      = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    localparam int ANG_W     = 16;
    localparam int OUT_W     = 16;
    localparam int FRAC_BITS = 24;
    localparam int ANG_SHIFT = 10;   // q3.13 to q24, doubled angle halved
    localparam int OUT_SHIFT = 10;   // q24 to q1.14
    localparam int Z_W       = 28;
    localparam int XY_W      = 27;
    localparam int PROD_W    = 28;
    localparam int SUM_W     = PROD_W + 1;

    // pipeline depth from input register to merged sums
    localparam int MERGE_LAT = 2;
    localparam int PIPE_LAT  = NUM_ITER + 1 + MERGE_LAT;

    typedef logic signed [ANG_W-1:0]  angle_t;
    typedef logic signed [OUT_W-1:0]  quat_t;
    typedef logic signed [Z_W-1:0]    z_t;
    typedef logic signed [XY_W-1:0]   xy_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        xy_t s;
        xy_t c;
    } sincos_t;

    typedef struct packed {
        quat_t x;
        quat_t y;
        quat_t z;
        quat_t w;
    } quat_res_t;

    localparam z_t  PI_Q24      = Z_W'(52707179);
    localparam z_t  HALF_PI_Q24 = Z_W'(26353589);
    localparam xy_t GAIN_Q24    = XY_W'(10188014);
    localparam int  OUT_MAX     = 16384;

    localparam logic signed [2*PROD_W-1:0] MUL_RND = (2*PROD_W)'(1) << (FRAC_BITS - 1);
    localparam sum_t OUT_RND = SUM_W'(1) << (OUT_SHIFT - 1);

    function automatic z_t atan_q24(input int idx);
        z_t v;
        case (idx)
            0:       v = Z_W'(13176795);
            1:       v = Z_W'(7778716);
            2:       v = Z_W'(4110060);
            3:       v = Z_W'(2086331);
            4:       v = Z_W'(1047214);
            5:       v = Z_W'(524117);
            6:       v = Z_W'(262123);
            7:       v = Z_W'(131069);
            8:       v = Z_W'(65536);
            9:       v = Z_W'(32768);
            10:      v = Z_W'(16384);
            11:      v = Z_W'(8192);
            12:      v = Z_W'(4096);
            13:      v = Z_W'(2048);
            14:      v = Z_W'(1024);
            15:      v = Z_W'(512);
            16:      v = Z_W'(256);
            17:      v = Z_W'(128);
            18:      v = Z_W'(64);
            19:      v = Z_W'(32);
            20:      v = Z_W'(16);
            21:      v = Z_W'(8);
            22:      v = Z_W'(4);
            23:      v = Z_W'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

    // q24 product, round half up
    function automatic prod_t mul_q24(input prod_t a, input prod_t b);
        logic signed [2*PROD_W-1:0] full;
        full = (2*PROD_W)'(a) * (2*PROD_W)'(b) + MUL_RND;
        return full[FRAC_BITS +: PROD_W];
    endfunction

    // q24 to q1.14 with rounding and clamp to plus or minus one
    function automatic quat_t to_out(input sum_t v);
        sum_t r;
        sum_t sh;
        quat_t q;
        r  = v + OUT_RND;
        sh = r >>> OUT_SHIFT;
        if (sh > SUM_W'(OUT_MAX)) begin
            q = OUT_W'(OUT_MAX);
        end else if (sh < -SUM_W'(OUT_MAX)) begin
            q = -OUT_W'(OUT_MAX);
        end else begin
            q = sh[OUT_W-1:0];
        end
        return q;
    endfunction

endpackage

/* hw/rtl/e2q_lane.sv */
module e2q_lane (
    input  logic             aclk,
    input  logic             en,
    input  e2q_pkg::angle_t  angle_i,
    output e2q_pkg::sincos_t sc_o
);
    import e2q_pkg::*;

    z_t   z_in;
    z_t   z_fold;
    logic flip_in;

    xy_t  x_reg    [NUM_ITER+1];
    xy_t  y_reg    [NUM_ITER+1];
    z_t   z_reg    [NUM_ITER+1];
    logic flip_reg [NUM_ITER+1];

    // half angle at q24, folded into plus or minus pi/2
    always_comb begin
        z_in = Z_W'(angle_i) <<< ANG_SHIFT;
        if (z_in > HALF_PI_Q24) begin
            z_fold  = z_in - PI_Q24;
            flip_in = 1'b1;
        end else if (z_in < -HALF_PI_Q24) begin
            z_fold  = z_in + PI_Q24;
            flip_in = 1'b1;
        end else begin
            z_fold  = z_in;
            flip_in = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= GAIN_Q24;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_fold;
            flip_reg[0] <= flip_in;
        end
    end

    for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
        xy_t dx;
        xy_t dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][Z_W-1]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_q24(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_q24(i);
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    assign sc_o.s = flip_reg[NUM_ITER] ? -y_reg[NUM_ITER] : y_reg[NUM_ITER];
    assign sc_o.c = flip_reg[NUM_ITER] ? -x_reg[NUM_ITER] : x_reg[NUM_ITER];

endmodule

/* hw/rtl/e2q_merge.sv */
module e2q_merge (
    input  logic               aclk,
    input  logic               en,
    input  e2q_pkg::sincos_t   scx_i,
    input  e2q_pkg::sincos_t   scy_i,
    input  e2q_pkg::sincos_t   scz_i,
    output e2q_pkg::quat_res_t res_o
);
    import e2q_pkg::*;

    prod_t sxcy_reg, cxsy_reg, cxcy_reg, sxsy_reg;
    prod_t cz_reg, sz_reg;
    prod_t t_sxcycz_reg, t_cxsysz_reg, t_cxsycz_reg, t_sxcysz_reg;
    prod_t t_cxcysz_reg, t_sxsycz_reg, t_cxcycz_reg, t_sxsysz_reg;

    // first factor pair
    always_ff @(posedge aclk) begin
        if (en) begin
            sxcy_reg <= mul_q24(PROD_W'(scx_i.s), PROD_W'(scy_i.c));
            cxsy_reg <= mul_q24(PROD_W'(scx_i.c), PROD_W'(scy_i.s));
            cxcy_reg <= mul_q24(PROD_W'(scx_i.c), PROD_W'(scy_i.c));
            sxsy_reg <= mul_q24(PROD_W'(scx_i.s), PROD_W'(scy_i.s));
            cz_reg   <= PROD_W'(scz_i.c);
            sz_reg   <= PROD_W'(scz_i.s);
        end
    end

    // third factor
    always_ff @(posedge aclk) begin
        if (en) begin
            t_sxcycz_reg <= mul_q24(sxcy_reg, cz_reg);
            t_cxsysz_reg <= mul_q24(cxsy_reg, sz_reg);
            t_cxsycz_reg <= mul_q24(cxsy_reg, cz_reg);
            t_sxcysz_reg <= mul_q24(sxcy_reg, sz_reg);
            t_cxcysz_reg <= mul_q24(cxcy_reg, sz_reg);
            t_sxsycz_reg <= mul_q24(sxsy_reg, cz_reg);
            t_cxcycz_reg <= mul_q24(cxcy_reg, cz_reg);
            t_sxsysz_reg <= mul_q24(sxsy_reg, sz_reg);
        end
    end

    assign res_o.x = to_out(SUM_W'(t_sxcycz_reg) - SUM_W'(t_cxsysz_reg));
    assign res_o.y = to_out(SUM_W'(t_cxsycz_reg) + SUM_W'(t_sxcysz_reg));
    assign res_o.z = to_out(SUM_W'(t_cxcysz_reg) - SUM_W'(t_sxsycz_reg));
    assign res_o.w = to_out(SUM_W'(t_cxcycz_reg) + SUM_W'(t_sxsysz_reg));

endmodule

/* hw/rtl/euler_to_quaternion.sv */
// euler_to_quaternion: xyz euler angles (q3.13) to unit quaternion (q1.14)
// path: input register, cordic iteration registers, merge product registers, output register
// throughput: one item per cycle while the skid is empty, set by the unrolled cordic lanes
// a result that waits on m_ready parks in a one-entry skid; input stalls only then
// reset (aresetn, synchronous, active low) empties the pipeline, output and skid
module euler_to_quaternion (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  e2q_pkg::angle_t     s_angle_x,
    input  e2q_pkg::angle_t     s_angle_y,
    input  e2q_pkg::angle_t     s_angle_z,
    output logic                m_valid,
    input  logic                m_ready,
    output e2q_pkg::quat_t      m_quat_x,
    output e2q_pkg::quat_t      m_quat_y,
    output e2q_pkg::quat_t      m_quat_z,
    output e2q_pkg::quat_t      m_quat_w
);
    import e2q_pkg::*;

    logic      en;
    sincos_t   scx, scy, scz;
    quat_res_t res;

    // valid bit riding along with each pipeline stage
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;

    // output register and skid entry
    logic      out_v_reg, out_v_next;
    quat_res_t out_reg, out_next;
    logic      skid_v_reg, skid_v_next;
    quat_res_t skid_reg, skid_next;

    // the whole pipeline moves as long as the skid is free
    assign en      = !skid_v_reg;
    assign s_ready = en;

    // one cordic lane per angle
    e2q_lane u_lane_x (.aclk(aclk), .en(en), .angle_i(s_angle_x), .sc_o(scx));
    e2q_lane u_lane_y (.aclk(aclk), .en(en), .angle_i(s_angle_y), .sc_o(scy));
    e2q_lane u_lane_z (.aclk(aclk), .en(en), .angle_i(s_angle_z), .sc_o(scz));

    // products of three factors and final rounding
    e2q_merge u_merge (
        .aclk  (aclk),
        .en    (en),
        .scx_i (scx),
        .scy_i (scy),
        .scz_i (scz),
        .res_o (res)
    );

    always_comb begin
        vld_next    = vld_reg;
        out_v_next  = out_v_reg;
        out_next    = out_reg;
        skid_v_next = skid_v_reg;
        skid_next   = skid_reg;
        if (en) begin
            vld_next = {vld_reg[PIPE_LAT-2:0], s_valid};
            if (vld_reg[PIPE_LAT-1]) begin
                if (!out_v_reg || m_ready) begin
                    // output free or being taken: new result goes straight out
                    out_next   = res;
                    out_v_next = 1'b1;
                end else begin
                    // output stalled: park the new result
                    skid_next   = res;
                    skid_v_next = 1'b1;
                end
            end else if (m_ready) begin
                out_v_next = 1'b0;
            end
        end else if (m_ready) begin
            // drain the skid into the output
            out_next    = skid_reg;
            skid_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            vld_reg    <= vld_next;
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid  = out_v_reg;
    assign m_quat_x = out_reg.x;
    assign m_quat_y = out_reg.y;
    assign m_quat_z = out_reg.z;
    assign m_quat_w = out_reg.w;

endmodule

/* hw/rtl/e2q_checker.sv */
module e2q_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input e2q_pkg::quat_t      m_quat_x,
    input e2q_pkg::quat_t      m_quat_w
);
    import e2q_pkg::*;

    // a waiting result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // reset leaves nothing on the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input only stalls while a result is held back
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> $past(m_valid) && !$past(m_ready))
        else $error("input stalled without output backpressure");

    // x and w components stay within plus or minus one
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_quat_x <= OUT_W'(OUT_MAX) && m_quat_x >= -OUT_W'(OUT_MAX)
                 && m_quat_w <= OUT_W'(OUT_MAX) && m_quat_w >= -OUT_W'(OUT_MAX))
        else $error("quaternion component out of range");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_quat_x (m_quat_x),
    .m_quat_w (m_quat_w)
);

/* tb/tb.sv */
module tb;
    import e2q_pkg::*;

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // input channel
    logic   s_valid = 1'b0;
    logic   s_ready;
    angle_t s_angle_x = '0;
    angle_t s_angle_y = '0;
    angle_t s_angle_z = '0;

    // result channel
    logic  m_valid;
    logic  m_ready = 1'b0;
    quat_t m_quat_x;
    quat_t m_quat_y;
    quat_t m_quat_z;
    quat_t m_quat_w;

    euler_to_quaternion uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_angle_x (s_angle_x),
        .s_angle_y (s_angle_y),
        .s_angle_z (s_angle_z),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_quat_x  (m_quat_x),
        .m_quat_y  (m_quat_y),
        .m_quat_z  (m_quat_z),
        .m_quat_w  (m_quat_w)
    );

    // expected quaternions, oldest first
    quat_res_t quat_fifo[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        rx_stall_on = 1'b1;

    localparam int  WATCHDOG = 5000;
    localparam longint PI_L      = 52707179;
    localparam longint HALF_PI_L = 26353589;
    localparam longint GAIN_L    = 10188014;
    localparam longint ATAN_L [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117,
        262123, 131069, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

    // q24 product, round half up (>>> on longint floors)
    function automatic longint q24_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< 23)) >>> 24;
    endfunction

    // sine and cosine of half the angle, quadrant folded
    function automatic void half_angle_sincos(angle_t ang, output longint s,
                                              output longint c);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        int     n;
        z    = longint'(ang) * 1024;
        flip = 1'b0;
        x    = GAIN_L;
        y    = 0;
        n    = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
        if (z > HALF_PI_L) begin
            z -= PI_L;
            flip = 1'b1;
        end else if (z < -HALF_PI_L) begin
            z += PI_L;
            flip = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ATAN_L[i];
            end else begin
                x += dx;
                y -= dy;
                z += ATAN_L[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // q24 sum down to q1.14, clamped to plus or minus one
    function automatic quat_t q24_to_q14(longint v);
        longint r;
        r = (v + 512) >>> 10;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return quat_t'(r);
    endfunction

    function automatic quat_res_t euler_to_quat(angle_t ax, angle_t ay, angle_t az);
        longint sx, cx, sy, cy, sz, cz;
        quat_res_t q;
        half_angle_sincos(ax, sx, cx);
        half_angle_sincos(ay, sy, cy);
        half_angle_sincos(az, sz, cz);
        q.x = q24_to_q14(q24_mul(q24_mul(sx, cy), cz) - q24_mul(q24_mul(cx, sy), sz));
        q.y = q24_to_q14(q24_mul(q24_mul(cx, sy), cz) + q24_mul(q24_mul(sx, cy), sz));
        q.z = q24_to_q14(q24_mul(q24_mul(cx, cy), sz) - q24_mul(q24_mul(sx, sy), cz));
        q.w = q24_to_q14(q24_mul(q24_mul(cx, cy), cz) + q24_mul(q24_mul(sx, sy), sz));
        return q;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // send one angle set; prediction is queued when the item is accepted
    task automatic send_angles(angle_t ax, angle_t ay, angle_t az, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        // valid may still be up from the previous item; idle it during a gap
        if (g != 0) s_valid <= 1'b0;
        repeat (g) @(posedge aclk);
        s_valid   <= 1'b1;
        s_angle_x <= ax;
        s_angle_y <= ay;
        s_angle_z <= az;
        do @(posedge aclk); while (!s_ready);
        quat_fifo.push_back(euler_to_quat(ax, ay, az));
    endtask

    task automatic drop_valid();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (quat_fifo.size() != 0) @(posedge aclk);
    endtask

    // extremes on each axis and the quadrant fold boundary on x and z
    task automatic test_extremes();
        angle_t v [10] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001,
                           16'sd12868, 16'sd12869, -16'sd12868, -16'sd12869, 16'sd25736};
        for (int i = 0; i < 10; i++) send_angles(v[i], 16'sh0000, 16'sh0000, 1'b0);
        for (int i = 0; i < 5; i++) send_angles(16'sh0000, v[i], v[9 - i], 1'b0);
        send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
        send_angles(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
        send_angles(16'sh5555, 16'shaaaa, 16'sh5555, 1'b0);
        send_angles(16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0);
        drop_valid();
    endtask

    // random angles, mostly with gaps, some back to back bursts
    task automatic test_random(int count);
        bit burst;
        for (int i = 0; i < count; i++) begin
            burst = ($urandom_range(0, 9) < 3);
            send_angles(angle_t'($urandom), angle_t'($urandom), angle_t'($urandom),
                        !burst);
        end
        drop_valid();
    endtask

    // sender holds off until the pipeline has fully drained, then refills
    task automatic test_drain_refill();
        wait_drained();
        test_random(40);
    endtask

    // receiver always ready, so results never wait; input still comes with random gaps
    task automatic test_full_rate();
        wait_drained();
        rx_stall_on = 1'b0;
        test_random(60);
        wait_drained();
        rx_stall_on = 1'b1;
    endtask

    // receiver side: random back pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!rx_stall_on) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) < 70) ||
                       ($urandom_range(0, 99) < 10 && !m_ready);
        end
    end

    // checker: compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        quat_res_t exp_q;
        if (aresetn && m_valid && m_ready) begin
            if (quat_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d w=%0d",
                             m_quat_x, m_quat_y, m_quat_z, m_quat_w);
            end else begin
                exp_q = quat_fifo.pop_front();
                if (m_quat_x !== exp_q.x || m_quat_y !== exp_q.y ||
                    m_quat_z !== exp_q.z || m_quat_w !== exp_q.w) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp x=%0d y=%0d z=%0d w=%0d got %0d %0d %0d %0d",
                                 exp_q.x, exp_q.y, exp_q.z, exp_q.w,
                                 m_quat_x, m_quat_y, m_quat_z, m_quat_w);
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_random(300);
        test_drain_refill();
        test_full_rate();
        test_random(330);
        wait_drained();
        repeat (PIPE_LAT + 10) @(posedge aclk);
        if (mismatches == 0 && quat_fifo.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
